@@ rtl/core/json_string_unescape_macros.svh @@
// assertion macros for the json string unescaper
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// same-cycle implication, checked after reset
`define JSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("json_string_unescape: assertion failed");

// next-cycle implication, checked after reset
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("json_string_unescape: assertion failed");

`endif

@@ rtl/core/jsu_pkg.sv @@
// types, codes and helper functions for the json string unescaper
package jsu_pkg;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_ESCAPE = 3'd1,
    M_HEX    = 3'd2,
    M_LOW    = 3'd3,
    M_COPY   = 3'd4,
    M_WAIT   = 3'd5
  } mode_t;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_EARLY_END = 3'd0;
  localparam logic [2:0] ERR_MB_ESC    = 3'd1;
  localparam logic [2:0] ERR_UNK_ESC   = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
  localparam logic [2:0] ERR_NO_LOW    = 3'd4;
  localparam logic [2:0] ERR_BAD_LOW   = 3'd5;

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [15:0] CP_HIGH_LO = 16'hD800;
  localparam logic [15:0] CP_HIGH_HI = 16'hDBFF;
  localparam logic [15:0] CP_LOW_LO  = 16'hDC00;
  localparam logic [15:0] CP_LOW_HI  = 16'hDFFF;
  localparam logic [10:0] PLANE_ONE  = 11'h040;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hexdig_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } enc_t;

  function automatic hexdig_t hex_digit(input logic [7:0] b);
    hexdig_t h;
    h = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h37);
    end
    return h;
  endfunction

  // length of a utf-8 sequence from its lead byte
  function automatic logic [2:0] seq_size(input logic [7:0] b);
    logic [2:0] n;
    if (b[7:3] == 5'b11110) n = 3'd4;
    else if (b[7:4] == 4'b1110) n = 3'd3;
    else if (b[7:5] == 3'b110) n = 3'd2;
    else n = 3'd1;
    return n;
  endfunction

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp[20:7] == '0) begin
      e.cnt      = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp[20:11] == '0) begin
      e.cnt      = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp[20:16] == '0) begin
      e.cnt      = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.cnt      = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

@@ rtl/core/json_string_unescape.sv @@
// json string body unescaper: raw body bytes in, unescaped utf-8 bytes and events out
//
//  channel | dir | tdata                        | tuser   | tlast
//  in_     | in  | [7:0] in_byte                | -       | buffer_end
//  out_    | out | [7:0] out_byte, [10:8] error | [1:0] kind | last result of request
//
// one input request is taken per cycle while out_tready is high, when it yields at most one result
// a request that yields more than one byte (a \u code point) holds in_tready low
//   while the 4-entry result register drains, one a cycle when out_tready is high
// a new request is taken in the same cycle the last buffered result leaves
// synchronous active-low reset returns the decoder to body mode, buffer empty
// stalls on out_ back up through in_tready only; nothing is dropped
module json_string_unescape (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] error_code, rest zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);

`include "json_string_unescape_macros.svh"

  // decoder state
  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [9:0]  hisur_r, hisur_nxt;

  // result register: up to four bytes or one event
  logic [2:0]      cnt_r, cnt_nxt;
  logic [3:0][7:0] dat_r, dat_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic [2:0]      err_r, err_nxt;

  logic            in_fire, out_fire;
  logic [7:0]      b;
  jsu_pkg::hexdig_t hv;
  logic [15:0]     hex_new;
  logic [3:0]      kh;      // digit count in hex mode, including this byte
  logic [2:0]      ssz;
  logic [20:0]     enc_cp;
  jsu_pkg::enc_t   enc;

  // what this request produces
  logic [1:0]      ev;      // KIND_DATA means no event
  logic [2:0]      ev_err;
  logic [3:0][7:0] d;
  logic [2:0]      nd;
  logic [2:0]      rem;
  logic [2:0]      rem_code;
  logic            do_defer;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;

  assign b       = in_tdata;
  assign hv      = jsu_pkg::hex_digit(b);
  assign hex_new = {hex_r[11:0], hv.val};
  assign kh      = {1'b0, pend_r} + 4'd1;
  assign ssz     = jsu_pkg::seq_size(b);

  // low surrogate path builds 0x10000 + ((high - 0xd800) << 10) + (low - 0xdc00)
  assign enc_cp = (mode_r == jsu_pkg::M_LOW)
                ? {11'(hisur_r) + jsu_pkg::PLANE_ONE, hex_new[9:0]}
                : {5'd0, hex_new};
  assign enc    = jsu_pkg::utf8_encode(enc_cp);

  // decode step
  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    hex_nxt   = hex_r;
    hisur_nxt = hisur_r;
    ev        = jsu_pkg::KIND_DATA;
    ev_err    = jsu_pkg::ERR_EARLY_END;
    d         = '0;
    nd        = 3'd0;
    do_defer  = 1'b0;
    rem       = 3'd0;
    rem_code  = jsu_pkg::ERR_EARLY_END;

    unique case (mode_r)
      jsu_pkg::M_ESCAPE: begin
        mode_nxt = jsu_pkg::M_NORMAL;
        if (ssz > 3'd1) begin
          do_defer = 1'b1;
          rem      = ssz - 3'd1;
          rem_code = jsu_pkg::ERR_MB_ESC;
        end else begin
          unique case (b)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
              d[0] = b;
              nd   = 3'd1;
            end
            jsu_pkg::CH_B: begin d[0] = 8'h08; nd = 3'd1; end
            jsu_pkg::CH_F: begin d[0] = 8'h0C; nd = 3'd1; end
            jsu_pkg::CH_N: begin d[0] = 8'h0A; nd = 3'd1; end
            jsu_pkg::CH_R: begin d[0] = 8'h0D; nd = 3'd1; end
            jsu_pkg::CH_T: begin d[0] = 8'h09; nd = 3'd1; end
            jsu_pkg::CH_U: begin
              mode_nxt = jsu_pkg::M_HEX;
              pend_nxt = 3'd0;
              hex_nxt  = '0;
            end
            default: begin
              ev     = jsu_pkg::KIND_ERROR;
              ev_err = jsu_pkg::ERR_UNK_ESC;
            end
          endcase
        end
      end
      jsu_pkg::M_HEX: begin
        if (!hv.ok) begin
          do_defer = 1'b1;
          rem      = 3'(4'd4 - kh);
          rem_code = jsu_pkg::ERR_BAD_HEX;
        end else begin
          hex_nxt  = hex_new;
          pend_nxt = kh[2:0];
          if (kh >= 4'd4) begin
            if (hex_new < jsu_pkg::CP_HIGH_LO || hex_new > jsu_pkg::CP_LOW_HI) begin
              d        = enc.bytes;
              nd       = enc.cnt;
              mode_nxt = jsu_pkg::M_NORMAL;
            end else if (hex_new <= jsu_pkg::CP_HIGH_HI) begin
              hisur_nxt = hex_new[9:0];
              mode_nxt  = jsu_pkg::M_LOW;
              pend_nxt  = 3'd0;
              hex_nxt   = '0;
            end else begin
              ev     = jsu_pkg::KIND_ERROR;
              ev_err = jsu_pkg::ERR_BAD_HEX;
            end
          end
        end
      end
      jsu_pkg::M_LOW: begin
        // expects backslash, u, then four hex digits
        if (pend_r < 3'd2) begin
          if (b != ((pend_r == 3'd0) ? jsu_pkg::CH_BSLASH : jsu_pkg::CH_U)) begin
            do_defer = 1'b1;
            rem      = 3'd5 - pend_r;
            rem_code = jsu_pkg::ERR_NO_LOW;
          end
        end else if (!hv.ok) begin
          do_defer = 1'b1;
          rem      = 3'd5 - pend_r;
          rem_code = jsu_pkg::ERR_BAD_LOW;
        end else begin
          hex_nxt = hex_new;
        end
        if (!do_defer) begin
          pend_nxt = pend_r + 3'd1;
          if (pend_r >= 3'd5) begin
            if (hex_new < jsu_pkg::CP_LOW_LO || hex_new > jsu_pkg::CP_LOW_HI) begin
              ev     = jsu_pkg::KIND_ERROR;
              ev_err = jsu_pkg::ERR_BAD_LOW;
            end else begin
              d        = enc.bytes;
              nd       = enc.cnt;
              mode_nxt = jsu_pkg::M_NORMAL;
            end
          end
        end
      end
      jsu_pkg::M_COPY: begin
        d[0] = b;
        nd   = 3'd1;
        if (pend_r <= 3'd1) begin
          pend_nxt = 3'd0;
          mode_nxt = jsu_pkg::M_NORMAL;
        end else begin
          pend_nxt = pend_r - 3'd1;
        end
      end
      jsu_pkg::M_WAIT: begin
        if (pend_r <= 3'd1) begin
          pend_nxt = 3'd0;
          ev       = jsu_pkg::KIND_ERROR;
          ev_err   = hex_r[2:0];
        end else begin
          pend_nxt = pend_r - 3'd1;
        end
      end
      default: begin
        // body mode; unused mode codes act the same
        if (ssz > 3'd1) begin
          d[0]     = b;
          nd       = 3'd1;
          mode_nxt = jsu_pkg::M_COPY;
          pend_nxt = ssz - 3'd1;
        end else if (b == jsu_pkg::CH_QUOTE) begin
          ev = jsu_pkg::KIND_CLOSE;
        end else if (b == jsu_pkg::CH_BSLASH) begin
          mode_nxt = jsu_pkg::M_ESCAPE;
        end else begin
          d[0] = b;
          nd   = 3'd1;
        end
      end
    endcase

    // error found before the escape's bytes are all in: report now or hold
    if (do_defer) begin
      d  = '0;
      nd = 3'd0;
      if (rem == 3'd0) begin
        ev     = jsu_pkg::KIND_ERROR;
        ev_err = rem_code;
      end else begin
        mode_nxt = jsu_pkg::M_WAIT;
        pend_nxt = rem;
        hex_nxt  = 16'(rem_code);
      end
    end

    // window ran out mid-string
    if (ev == jsu_pkg::KIND_DATA && in_tlast) begin
      ev     = jsu_pkg::KIND_ERROR;
      ev_err = jsu_pkg::ERR_EARLY_END;
    end

    // close or error starts a fresh string
    if (ev != jsu_pkg::KIND_DATA) begin
      mode_nxt  = jsu_pkg::M_NORMAL;
      pend_nxt  = 3'd0;
      hex_nxt   = '0;
      hisur_nxt = '0;
    end
  end

  // result register load and drain
  always_comb begin
    cnt_nxt  = cnt_r;
    dat_nxt  = dat_r;
    kind_nxt = kind_r;
    err_nxt  = err_r;
    if (in_fire) begin
      if (ev != jsu_pkg::KIND_DATA) begin
        cnt_nxt  = 3'd1;
        dat_nxt  = '0;
        kind_nxt = ev;
        err_nxt  = (ev == jsu_pkg::KIND_ERROR) ? ev_err : jsu_pkg::ERR_EARLY_END;
      end else begin
        cnt_nxt  = nd;
        dat_nxt  = d;
        kind_nxt = jsu_pkg::KIND_DATA;
        err_nxt  = jsu_pkg::ERR_EARLY_END;
      end
    end else if (out_fire) begin
      cnt_nxt = cnt_r - 3'd1;
      dat_nxt = dat_r >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jsu_pkg::M_NORMAL;
      pend_r  <= 3'd0;
      hex_r   <= '0;
      hisur_r <= '0;
      cnt_r   <= 3'd0;
    end else begin
      if (in_fire) begin
        mode_r  <= mode_nxt;
        pend_r  <= pend_nxt;
        hex_r   <= hex_nxt;
        hisur_r <= hisur_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dat_r  <= dat_nxt;
    kind_r <= kind_nxt;
    err_r  <= err_nxt;
  end

  // take a new request when the buffer is empty or its last result leaves now
  assign in_tready  = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_tready);
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {5'd0, err_r, dat_r[0]};
  assign out_tuser  = kind_r;
  assign out_tlast  = (cnt_r == 3'd1);

  // close and error results stand alone
  `JSU_ASSERT_NOW(a_event_single, out_tvalid && out_tuser != jsu_pkg::KIND_DATA, out_tlast)
  // result register never holds more than four entries
  `JSU_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= 3'd4)
  // end of window always returns the decoder to body mode
  `JSU_ASSERT_NEXT(a_end_resets, in_fire && in_tlast, mode_r == jsu_pkg::M_NORMAL && pend_r == 3'd0)
  // a held error always still waits on at least one byte
  `JSU_ASSERT_NOW(a_wait_pending, mode_r == jsu_pkg::M_WAIT, pend_r != 3'd0)

endmodule

@@ dv/jsu_checker.sv @@
// request/result checker for the json string unescaper: predicts the decoded stream and compares
module jsu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  input  logic        in_tlast,    // buffer_end
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // [7:0] out_byte, [10:8] error_code
  input  logic [1:0]  out_tuser,   // [1:0] kind
  input  logic        out_tlast,
  output int          fail_count,
  output int          open_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam logic [20:0] PLANE_BASE = 21'h10000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] code;
    logic       last;
  } result_t;

  result_t     pending_results[$];
  result_t     oldest;
  int          errs = 0;

  // shadow of the decoder state
  mode_t       dec_mode = M_NORMAL;
  logic [2:0]  dec_cnt  = '0;
  logic [15:0] dec_acc  = '0;
  logic [9:0]  dec_high = '0;

  // {valid, nibble}
  function automatic logic [4:0] ascii_hex(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  function automatic int lead_len(input logic [7:0] c);
    casez (c)
      8'b11110???: return 4;
      8'b1110????: return 3;
      8'b110?????: return 2;
      default:     return 1;
    endcase
  endfunction

  task automatic utf8_of(input logic [20:0] cp, output logic [3:0][7:0] seq, output int n);
    seq = '0;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < PLANE_BASE) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      n = 4;
    end
  endtask

  // error known now; reported at once unless the escape still owes bytes
  task automatic hold_error(input logic [2:0] c, input int remaining, output logic now);
    now = (remaining == 0);
    if (!now) begin
      dec_mode = M_WAIT;
      dec_cnt  = 3'(remaining);
      dec_acc  = 16'(c);
    end
  endtask

  task automatic unescape_byte(input logic [7:0] b, input logic fin);
    logic [3:0][7:0] seq;
    int              n;
    int              k;
    int              i;
    logic            done;
    logic [1:0]      ev;
    logic [2:0]      code;
    logic [4:0]      hx;
    seq  = '0;
    n    = 0;
    done = 1'b0;
    ev   = KIND_ERROR;
    code = ERR_EARLY_END;
    case (dec_mode)
      M_ESCAPE: begin
        k = lead_len(b);
        dec_mode = M_NORMAL;
        if (k > 1) begin
          code = ERR_MB_ESC;
          hold_error(ERR_MB_ESC, k - 1, done);
        end else begin
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: begin seq[0] = b;     n = 1; end
            CH_B:                          begin seq[0] = 8'h08; n = 1; end
            CH_F:                          begin seq[0] = 8'h0C; n = 1; end
            CH_N:                          begin seq[0] = 8'h0A; n = 1; end
            CH_R:                          begin seq[0] = 8'h0D; n = 1; end
            CH_T:                          begin seq[0] = 8'h09; n = 1; end
            CH_U: begin
              dec_mode = M_HEX;
              dec_cnt  = '0;
              dec_acc  = '0;
            end
            default: begin
              done = 1'b1;
              code = ERR_UNK_ESC;
            end
          endcase
        end
      end
      M_HEX: begin
        k = dec_cnt + 1;
        hx = ascii_hex(b);
        code = ERR_BAD_HEX;
        if (!hx[4]) begin
          hold_error(ERR_BAD_HEX, 4 - k, done);
        end else begin
          dec_acc = {dec_acc[11:0], hx[3:0]};
          dec_cnt = 3'(k);
          if (k == 4) begin
            if (dec_acc < CP_HIGH_LO || dec_acc > CP_LOW_HI) begin
              utf8_of({5'd0, dec_acc}, seq, n);
              dec_mode = M_NORMAL;
            end else if (dec_acc <= CP_HIGH_HI) begin
              dec_high = 10'(dec_acc - CP_HIGH_LO);
              dec_mode = M_LOW;
              dec_cnt  = '0;
              dec_acc  = '0;
            end else begin
              // low half with no high half before it
              done = 1'b1;
            end
          end
        end
      end
      M_LOW: begin
        k = dec_cnt;
        if (k < 2) begin
          code = ERR_NO_LOW;
          if (b != ((k == 0) ? CH_BSLASH : CH_U)) hold_error(ERR_NO_LOW, 5 - k, done);
          else dec_cnt = 3'(k + 1);
        end else begin
          hx = ascii_hex(b);
          code = ERR_BAD_LOW;
          if (!hx[4]) begin
            hold_error(ERR_BAD_LOW, 5 - k, done);
          end else begin
            dec_acc = {dec_acc[11:0], hx[3:0]};
            dec_cnt = 3'(k + 1);
            if (k == 5) begin
              if (dec_acc < CP_LOW_LO || dec_acc > CP_LOW_HI) begin
                done = 1'b1;
              end else begin
                utf8_of(PLANE_BASE + {dec_high, 10'd0} + 21'(dec_acc - CP_LOW_LO), seq, n);
                dec_mode = M_NORMAL;
              end
            end
          end
        end
      end
      M_COPY: begin
        seq[0] = b;
        n = 1;
        if (dec_cnt != 0) dec_cnt = dec_cnt - 3'd1;
        if (dec_cnt == 0) dec_mode = M_NORMAL;
      end
      M_WAIT: begin
        if (dec_cnt != 0) dec_cnt = dec_cnt - 3'd1;
        if (dec_cnt == 0) begin
          done = 1'b1;
          code = dec_acc[2:0];
        end
      end
      default: begin
        k = lead_len(b);
        if (k > 1) begin
          seq[0]   = b;
          n        = 1;
          dec_mode = M_COPY;
          dec_cnt  = 3'(k - 1);
        end else if (b == CH_QUOTE) begin
          done = 1'b1;
          ev   = KIND_CLOSE;
        end else if (b == CH_BSLASH) begin
          dec_mode = M_ESCAPE;
        end else begin
          seq[0] = b;
          n = 1;
        end
      end
    endcase

    // window ran out: drop this byte's data, report early end
    if (!done && fin) begin
      done = 1'b1;
      ev   = KIND_ERROR;
      code = ERR_EARLY_END;
    end

    if (done) begin
      dec_mode = M_NORMAL;
      dec_cnt  = '0;
      dec_acc  = '0;
      dec_high = '0;
      pending_results.push_back('{kind: ev, data: 8'h00,
                                  code: (ev == KIND_ERROR) ? code : 3'd0, last: 1'b1});
    end else begin
      for (i = 0; i < n; i++)
        pending_results.push_back('{kind: KIND_DATA, data: seq[i], code: 3'd0,
                                    last: (i == n - 1)});
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dec_mode = M_NORMAL;
      dec_cnt  = '0;
      dec_acc  = '0;
      dec_high = '0;
      pending_results.delete();
    end else begin
      // push first so a same-cycle result still meets the oldest expectation
      if (in_tvalid && in_tready) unescape_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d out_byte %0h error_code %0d last %0b",
                 out_tuser, out_tdata[7:0], out_tdata[10:8], out_tlast);
          errs++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("kind",       8'(oldest.kind), 8'(out_tuser));
          check_field("out_byte",   oldest.data,     out_tdata[7:0]);
          check_field("error_code", 8'(oldest.code), 8'(out_tdata[10:8]));
          check_field("last",       8'(oldest.last), 8'(out_tlast));
        end
      end
    end
    fail_count   <= errs;
    open_results <= pending_results.size();
  end

endmodule

@@ dv/testbench.sv @@
// top of the json string unescaper testbench: stimulus, idling phases and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  // ascii hex digit bounds
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  localparam int PHASE_BYTES    = 16;    // minimum random requests per idling phase
  localparam int DRAIN_CYCLES   = 16;    // settle time once nothing is owed
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request or result moving

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int open_results;
  int send_idle = 0;   // percent of cycles the sender holds back
  int stall_pct = 0;   // percent of cycles the receiver stalls
  int quiet     = 0;

  typedef struct {
    logic [7:0] b;
    logic       e;
  } body_byte_t;

  body_byte_t feed_q[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  json_string_unescape u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  jsu_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .open_results (open_results)
  );

  // receiver: one ready decision per cycle, rate set by the current phase
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: nothing moving on either channel for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b);
    feed_q.push_back('{b, 1'b0});
  endtask

  // hex digit in either case, picked at random
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 4'd10);
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
           (c >= CH_UPPER_A && c <= CH_UPPER_F));
    return c;
  endfunction

  // utf-8 lead byte of an n-byte sequence with random payload bits
  function automatic logic [7:0] lead_byte(input int n);
    case (n)
      2:       return 8'hC0 | 8'($urandom_range(8'h1F));
      3:       return 8'hE0 | 8'($urandom_range(8'h0F));
      default: return 8'hF0 | 8'($urandom_range(8'h07));
    endcase
  endfunction

  // backslash-u escape with four hex digits
  task automatic put_u(input logic [15:0] v);
    int i;
    put(CH_BSLASH);
    put(CH_U);
    for (i = 3; i >= 0; i--) put(hex_char(v[i*4 +: 4]));
  endtask

  // backslash-u with one non-hex digit at a random spot, the rest hex
  task automatic put_bad_u();
    int i;
    int at;
    put(CH_BSLASH);
    put(CH_U);
    at = $urandom_range(3);
    for (i = 0; i < 4; i++) put((i == at) ? non_hex() : hex_char(4'($urandom_range(15))));
  endtask

  // one piece of string body: mostly well formed, some noise and broken escapes
  task automatic put_token();
    int          pick;
    int          i;
    int          n;
    logic [7:0]  c;
    logic [15:0] v;
    pick = $urandom_range(19);
    case (pick)
      0, 1, 2, 3, 4, 17, 18: begin
        // plain ascii, neither quote nor backslash
        do c = 8'($urandom_range(127)); while (c == CH_QUOTE || c == CH_BSLASH);
        put(c);
      end
      5, 6: begin
        put(CH_BSLASH);
        case ($urandom_range(7))
          0:       put(CH_QUOTE);
          1:       put(CH_BSLASH);
          2:       put(CH_SLASH);
          3:       put(CH_B);
          4:       put(CH_F);
          5:       put(CH_N);
          6:       put(CH_R);
          default: put(CH_T);
        endcase
      end
      7, 8: begin
        // basic-plane code point, spread over the three encoded sizes
        case ($urandom_range(3))
          0:       v = 16'($urandom_range(16'h007F));
          1:       v = 16'($urandom_range(16'h07FF, 16'h0080));
          2:       v = 16'($urandom_range(16'hD7FF, 16'h0800));
          default: v = 16'($urandom_range(16'hFFFF, 16'hE000));
        endcase
        put_u(v);
      end
      9: begin
        // surrogate pair
        put_u(16'($urandom_range(CP_HIGH_HI, CP_HIGH_LO)));
        put_u(16'($urandom_range(CP_LOW_HI, CP_LOW_LO)));
      end
      10, 11: begin
        // raw multi-byte character copied through
        n = $urandom_range(4, 2);
        put(lead_byte(n));
        for (i = 1; i < n; i++) put(8'h80 | 8'($urandom_range(8'h3F)));
      end
      13: begin
        put(CH_BSLASH);
        if ($urandom_range(1)) begin
          // unknown escape letter
          do c = 8'($urandom_range(127));
          while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
          put(c);
        end else begin
          // multi-byte character after backslash, its tail still consumed
          n = $urandom_range(4, 2);
          put(lead_byte(n));
          for (i = 1; i < n; i++) put(8'($urandom_range(255)));
        end
      end
      14: put_bad_u();
      15: put_u(16'($urandom_range(CP_LOW_HI, CP_LOW_LO)));  // lone low half
      16: begin
        put_u(16'($urandom_range(CP_HIGH_HI, CP_HIGH_LO)));
        case ($urandom_range(3))
          0: begin
            // no backslash after the high half
            do c = 8'($urandom_range(255)); while (c == CH_BSLASH);
            put(c);
            for (i = 0; i < 5; i++) put(8'($urandom_range(255)));
          end
          1: begin
            // backslash but not u
            put(CH_BSLASH);
            do c = 8'($urandom_range(255)); while (c == CH_U);
            put(c);
            for (i = 0; i < 4; i++) put(8'($urandom_range(255)));
          end
          2: begin
            // second escape is not a low half
            do v = 16'($urandom_range(16'hFFFF)); while (v >= CP_LOW_LO && v <= CP_LOW_HI);
            put_u(v);
          end
          default: put_bad_u();
        endcase
      end
      default: put(8'($urandom_range(255)));  // noise
    endcase
  endtask

  task automatic put_string();
    int n;
    int i;
    n = $urandom_range(6, 1);
    for (i = 0; i < n; i++) put_token();
    if ($urandom_range(9) != 0) put(CH_QUOTE);
  endtask

  // present one request, with random sender gaps, until it is taken
  task automatic send(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // send everything queued, then hold off until every owed result is out
  task automatic drain_feed();
    body_byte_t it;
    while (feed_q.size() != 0) begin
      it = feed_q.pop_front();
      send(it.b, it.e);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall);
    send_idle = idle;
    stall_pct <= stall;
    feed_q.delete();
    while (feed_q.size() < PHASE_BYTES) put_string();
    // the window may end anywhere, including in the middle of an escape
    foreach (feed_q[j]) if ($urandom_range(29) == 0) feed_q[j].e = 1'b1;
    drain_feed();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, a short escape, 2-byte and 4-byte code points,
    // close, then a window that ends before the string does
    put(8'h41);
    put(8'h00);
    put(8'h7F);
    put(8'hFF);
    put(CH_BSLASH);
    put(CH_N);
    put_u(16'h00E9);
    put_u(16'hD83D);
    put_u(16'hDE00);
    put(CH_QUOTE);
    feed_q.push_back('{8'h80, 1'b1});
    drain_feed();

    // random body bytes under each idling mix
    run_phase(0, 0);
    run_phase(53, 0);
    run_phase(0, 53);
    run_phase(10, 10);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
